// ===== rtl/core/timing_wheel_timer_table_assert.svh =====
// Assertion macros used by the timer table sequencer.
// Each macro expects a clock named clk and a reset named rst in the including module.
`ifndef TIMING_WHEEL_TIMER_TABLE_ASSERT_SVH
`define TIMING_WHEEL_TIMER_TABLE_ASSERT_SVH

// Checks an implication or condition outside reset.
`define TWTT_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("timer table check failed");

// Checks that a consequence holds in the cycle after its antecedent.
`define TWTT_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer table check failed");

`endif

// ===== rtl/core/twtt_pkg.sv =====
// Package of the timer table: operation and event codes, the ring entry type,
// the sequencer states and the wheel modulo function. Depends on nothing.
package twtt_pkg;

  localparam int ID_W  = 16;
  localparam int DLY_W = 6;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REFRESH,
    OP_CANCEL,
    OP_TICK
  } op_t;

  typedef enum logic [2:0] {
    EV_OK,
    EV_FIRED,
    EV_SILENT,
    EV_FULL,
    EV_NOT_FOUND,
    EV_TICK_DONE
  } event_t;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [DLY_W-1:0] dly;
    logic [DLY_W-1:0] rem;
    logic             sil;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY,
    ST_RESULT,
    ST_TICK,
    ST_DONE
  } state_t;

  // Remainder of an 8-bit value by a constant non-zero 6-bit modulus, taken by
  // comparing with and subtracting those shifted multiples that fit in 8 bits.
  function automatic logic [DLY_W-1:0] wheel_mod(input logic [7:0] v,
                                                 input logic [DLY_W-1:0] w);
    logic [14:0] m;
    logic [7:0]  r;
    r = v;
    for (int k = 7; k >= 0; k--) begin
      m = 15'(w) << k;
      if (m <= 15'd255 && {7'd0, r} >= m) begin
        r = r - m[7:0];
      end
    end
    return r[DLY_W-1:0];
  endfunction

endpackage

// ===== rtl/core/twtt_cell.sv =====
// One cell of the timer ring: holds a single timer entry and passes it on.
// Depends on twtt_pkg for the entry type.
module twtt_cell
  import twtt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  entry_t d,
  output entry_t q
);

  logic             valid;
  logic [ID_W-1:0]  id;
  logic [DLY_W-1:0] dly;
  logic [DLY_W-1:0] rem;
  logic             sil;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      id  <= d.id;
      dly <= d.dly;
      rem <= d.rem;
      sil <= d.sil;
    end
  end

  assign q = '{valid: valid, id: id, dly: dly, rem: rem, sil: sil};

endmodule

// ===== rtl/core/twtt_ctrl.sv =====
// Sequencer of the timer table: takes input words, walks the ring of cells one entry a cycle
// (held while a tick waits on a full output register) and drives the output register. Depends on twtt_pkg.
`include "timing_wheel_timer_table_assert.svh"

module twtt_ctrl
  import twtt_pkg::*;
#(
  parameter int TIMER_SLOTS = 16,
  parameter int WHEEL_SIZE  = 60,
  parameter int ID_WIDTH    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic [2:0]  m_tuser,
  output logic        m_tlast,
  input  entry_t      head,
  output entry_t      feed,
  output logic        shift
);

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TIMER_SLOTS - 1);
  localparam logic [DLY_W-1:0] WHEEL = DLY_W'(WHEEL_SIZE);
  localparam logic [ID_W-1:0] ID_MASK =
    (ID_WIDTH >= ID_W) ? {ID_W{1'b1}} : ID_W'((1 << ID_WIDTH) - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] step;
  op_t              op;
  logic [ID_W-1:0]  cmd_id;
  logic [DLY_W-1:0] cmd_dly;
  logic             found, free_found;
  logic [IDX_W-1:0] found_idx, free_idx;
  logic             out_valid, out_last;
  event_t           out_kind;
  logic [ID_W-1:0]  out_id;

  logic             accept, out_free, tgt_hit, expire, last_step;
  logic [IDX_W-1:0] tgt_idx;
  logic [DLY_W-1:0] rem_dec, dly_mod;
  logic             load, ld_last;
  event_t           ld_kind;
  logic [ID_W-1:0]  ld_id;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;
  assign last_step = (step == LAST_STEP);
  assign tgt_hit   = found || (op == OP_ADD && free_found);
  assign tgt_idx   = found ? found_idx : free_idx;
  assign rem_dec   = (head.rem != '0) ? head.rem - DLY_W'(1) : head.rem;
  assign expire    = head.valid && (rem_dec == '0);
  assign dly_mod   = wheel_mod(s_tdata[23:16], WHEEL);

  always_comb begin
    state_next = state;
    unique case (state) inside
      ST_IDLE: begin
        if (accept) begin
          state_next = (op_t'(s_tuser) == OP_TICK) ? ST_TICK : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (last_step) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (last_step) state_next = ST_RESULT;
      end
      ST_TICK: begin
        if (shift && last_step) state_next = ST_DONE;
      end
      ST_RESULT, ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    shift   = 1'b0;
    feed    = head;
    load    = 1'b0;
    ld_kind = EV_OK;
    ld_id   = '0;
    ld_last = 1'b0;
    unique case (state)
      ST_IDLE: begin
      end
      ST_SEARCH: begin
        shift = 1'b1;
      end
      ST_APPLY: begin
        shift = 1'b1;
        if (tgt_hit && step == tgt_idx) begin
          case (op)
            OP_ADD: begin
              feed.valid = 1'b1;
              feed.id    = cmd_id;
              feed.dly   = cmd_dly;
              feed.rem   = cmd_dly;
              feed.sil   = 1'b0;
            end
            OP_REFRESH: feed.rem = head.dly;
            OP_CANCEL:  feed.sil = 1'b1;
            default: begin
            end
          endcase
        end
      end
      ST_TICK: begin
        if (head.valid) feed.rem = rem_dec;
        if (expire) begin
          feed.valid = 1'b0;
          if (out_free) begin
            shift   = 1'b1;
            load    = 1'b1;
            ld_kind = head.sil ? EV_SILENT : EV_FIRED;
            ld_id   = head.id;
          end
        end else begin
          shift = 1'b1;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = tgt_hit ? EV_OK : ((op == OP_ADD) ? EV_FULL : EV_NOT_FOUND);
          ld_id   = cmd_id;
          ld_last = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = EV_TICK_DONE;
          ld_last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (shift) step <= last_step ? '0 : step + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= op_t'(s_tuser);
      cmd_id     <= s_tdata[15:0] & ID_MASK;
      cmd_dly    <= (dly_mod == '0) ? WHEEL : dly_mod;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (state == ST_SEARCH) begin
      if (head.valid && head.id == cmd_id && !found) begin
        found     <= 1'b1;
        found_idx <= step;
      end
      if (!head.valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind <= ld_kind;
      out_id   <= ld_id;
      out_last <= ld_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_id;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  `TWTT_CHECK(a_idle_step_zero, (state == ST_IDLE) |-> (step == '0))
  `TWTT_CHECK_NEXT(a_tick_stall_holds, state == ST_TICK && !shift, $stable(step))
  `TWTT_CHECK(a_inner_only_in_tick, (load && !ld_last) |-> (state == ST_TICK))
  `TWTT_CHECK_NEXT(a_close_is_last, (state == ST_RESULT || state == ST_DONE) && out_free,
                   m_tvalid && m_tlast)

endmodule

// ===== rtl/core/timing_wheel_timer_table.sv =====
// Top level of the timer table: a ring of timer cells and its sequencer.
// Depends on twtt_pkg, twtt_cell and twtt_ctrl.
//
//   channel  direction  words
//   s_*      in         one command or tick per word
//   m_*      out        one event per word, tlast on the closing word of a run
//
// A command takes one revolution of the ring to search, one to apply, then the
// result word. A tick takes one ring step per slot, then the closing word.
// Either is held while a word waits on a full output register. Reset clears
// every valid bit at once, so the block accepts words in the cycle after reset.
// Commands and the next input word can be taken while the previous result word
// waits in the output register.
module timing_wheel_timer_table
  import twtt_pkg::*;
#(
  parameter int TIMER_SLOTS = 16,
  parameter int WHEEL_SIZE  = 60,
  parameter int ID_WIDTH    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // timer_id [15:0], delay_ticks [23:16]
  input  logic [1:0]  s_tuser,  // operation [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // event_id [15:0]
  output logic [2:0]  m_tuser,  // event_kind [2:0]
  output logic        m_tlast   // last_of_run
);

  entry_t ring [TIMER_SLOTS];
  entry_t feed;
  logic   shift;

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    entry_t d;
    if (i == TIMER_SLOTS - 1) begin : g_tail
      assign d = feed;
    end else begin : g_mid
      assign d = ring[i+1];
    end
    twtt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (d),
      .q     (ring[i])
    );
  end

  twtt_ctrl #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .WHEEL_SIZE  (WHEEL_SIZE),
    .ID_WIDTH    (ID_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .head     (ring[0]),
    .feed     (feed),
    .shift    (shift)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the timer table: directed and random command and tick
// streams with prediction of every event word. Depends on twtt_pkg and the block RTL.
module tb_top
  import twtt_pkg::*;
;

  localparam int TIMER_SLOTS    = 16;
  localparam int WHEEL_SIZE     = 60;
  localparam int POOL_SIZE      = 24;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 2 * TIMER_SLOTS + 4;

  typedef struct packed {
    event_t      kind;
    logic [15:0] id;
    logic        last;
  } event_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  event_word_t expected_events[$];
  int          n_errors = 0;
  int          quiet_cycles = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  logic [15:0] id_pool[POOL_SIZE];

  // Predicted contents of the timer table.
  bit          tmr_valid[TIMER_SLOTS];
  logic [15:0] tmr_id[TIMER_SLOTS];
  logic [5:0]  tmr_delay[TIMER_SLOTS];
  logic [5:0]  tmr_left[TIMER_SLOTS];
  bit          tmr_silent[TIMER_SLOTS];

  timing_wheel_timer_table #(
    .TIMER_SLOTS(TIMER_SLOTS),
    .WHEEL_SIZE (WHEEL_SIZE),
    .ID_WIDTH   (16)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void push_event(event_t kind, logic [15:0] id, logic last);
    event_word_t w;
    w.kind = kind;
    w.id   = id;
    w.last = last;
    expected_events.insert(expected_events.size(), w);
  endfunction

  function automatic void predict_timer_events(op_t op, logic [15:0] id, logic [7:0] dly);
    int         slot;
    logic [5:0] d;
    slot = -1;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (tmr_valid[i] && tmr_id[i] == id) slot = i;
    end
    case (op) inside
      OP_ADD: begin
        d = 6'(dly % WHEEL_SIZE);
        if (d == 0) d = 6'(WHEEL_SIZE);
        if (slot < 0) begin
          for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!tmr_valid[i]) slot = i;
          end
        end
        if (slot < 0) begin
          push_event(EV_FULL, id, 1'b1);
        end else begin
          tmr_valid[slot]  = 1'b1;
          tmr_id[slot]     = id;
          tmr_delay[slot]  = d;
          tmr_left[slot]   = d;
          tmr_silent[slot] = 1'b0;
          push_event(EV_OK, id, 1'b1);
        end
      end
      OP_REFRESH, OP_CANCEL: begin
        if (slot < 0) begin
          push_event(EV_NOT_FOUND, id, 1'b1);
        end else begin
          if (op == OP_REFRESH) tmr_left[slot] = tmr_delay[slot];
          else tmr_silent[slot] = 1'b1;
          push_event(EV_OK, id, 1'b1);
        end
      end
      default: begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (tmr_valid[i]) begin
            if (tmr_left[i] > 0) tmr_left[i] = tmr_left[i] - 6'd1;
            if (tmr_left[i] == 0) begin
              tmr_valid[i] = 1'b0;
              push_event(tmr_silent[i] ? EV_SILENT : EV_FIRED, tmr_id[i], 1'b0);
            end
          end
        end
        push_event(EV_TICK_DONE, 16'h0000, 1'b1);
      end
    endcase
  endfunction

  // The word is predicted at the edge that accepts it; valid stays high for a
  // following word unless a gap is drawn.
  task automatic send_word(op_t op, logic [15:0] id, logic [7:0] dly);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {dly, id};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_timer_events(op, id, dly);
  endtask

  task automatic wait_until_drained(int tail);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic test_empty_and_unknown();
    send_word(OP_TICK, 16'h0000, 8'h00);
    send_word(OP_REFRESH, 16'h0042, 8'hFF);
    send_word(OP_CANCEL, 16'hFFFF, 8'h00);
  endtask

  task automatic test_commands_and_expiry();
    send_word(OP_ADD, 16'h0000, 8'd0);
    send_word(OP_ADD, 16'hFFFF, 8'd255);
    send_word(OP_ADD, 16'h1234, 8'd1);
    send_word(OP_ADD, 16'hABCD, 8'd61);
    send_word(OP_ADD, 16'h5555, 8'd59);
    send_word(OP_ADD, 16'h1234, 8'd2);
    send_word(OP_CANCEL, 16'h5555, 8'd0);
    send_word(OP_CANCEL, 16'h5555, 8'd0);
    send_word(OP_REFRESH, 16'h5555, 8'd0);
    send_word(OP_REFRESH, 16'hFFFF, 8'd0);
    send_word(OP_CANCEL, 16'hABCD, 8'd0);
    send_word(OP_TICK, 16'h0000, 8'd0);
    send_word(OP_TICK, 16'h0000, 8'd0);
    send_word(OP_REFRESH, 16'hABCD, 8'd0);
  endtask

  task automatic test_table_full();
    for (int k = 0; k < 14; k++) send_word(OP_ADD, 16'h1000 + 16'(k), 8'd3);
    send_word(OP_ADD, 16'h1000, 8'd63);
    send_word(OP_CANCEL, 16'h1001, 8'd0);
    repeat (3) send_word(OP_TICK, 16'h0000, 8'd0);
  endtask

  task automatic test_full_revolution();
    repeat (WHEEL_SIZE) send_word(OP_TICK, 16'h0000, 8'd0);
    for (int k = 0; k < TIMER_SLOTS; k++) send_word(OP_ADD, 16'hF000 + 16'(k * 16'h0111), 8'd62);
    repeat (2) send_word(OP_TICK, 16'h0000, 8'd0);
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
    int          r;
    op_t         op;
    logic [15:0] id;
    logic [7:0]  dly;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      r   = $urandom_range(99);
      id  = ($urandom_range(9) == 0) ? 16'($urandom) : id_pool[$urandom_range(POOL_SIZE - 1)];
      dly = 8'($urandom);
      if (r < 35) begin
        op = OP_ADD;
        case ($urandom_range(9))
          0, 1: dly = 8'($urandom);
          2:    dly = 8'($urandom_range(WHEEL_SIZE, WHEEL_SIZE + 6));
          default: dly = 8'($urandom_range(1, 6));
        endcase
      end else if (r < 45) begin
        op = OP_REFRESH;
      end else if (r < 55) begin
        op = OP_CANCEL;
      end else begin
        op = OP_TICK;
      end
      send_word(op, id, dly);
    end
    wait_until_drained(0);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected word kind=%0d id=%h last=%b", $time, m_tuser, m_tdata,
                 m_tlast);
        n_errors++;
      end else begin
        event_word_t w;
        w = expected_events.pop_front();
        if (m_tuser !== w.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, w.kind, m_tuser);
          n_errors++;
        end
        if (m_tdata !== w.id) begin
          $display("%0t: id expected %h actual %h", $time, w.id, m_tdata);
          n_errors++;
        end
        if (m_tlast !== w.last) begin
          $display("%0t: last expected %b actual %b", $time, w.last, m_tlast);
          n_errors++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < TIMER_SLOTS; i++) tmr_valid[i] = 1'b0;
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = 16'($urandom);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_unknown();
    test_commands_and_expiry();
    test_table_full();
    test_full_revolution();
    wait_until_drained(0);
    test_random_traffic(48, 0, 0);
    test_random_traffic(48, 72, 0);
    test_random_traffic(48, 0, 72);
    test_random_traffic(48, 26, 26);
    wait_until_drained(TAIL_CYCLES);

    if (n_errors == 0 && expected_events.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
